// ===== src/jhc_pkg.sv =====
`default_nettype none

package jhc_pkg;

   // default sizes of the table
   localparam int MAX_VARS_DEFAULT   = 4;
   localparam int BIN_BITS_DEFAULT   = 3;
   localparam int COUNT_BITS_DEFAULT = 20;

   // fixed field geometry
   localparam int VALUE_FIELDS  = 4;
   localparam int VALUE_BITS    = 3;
   localparam int MASK_BITS     = 4;
   localparam int OP_BITS       = 2;
   localparam int VARS_BITS     = 3;
   localparam int BINS_BITS     = 4;

   // control register port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 4;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_VARS_IN_USE = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINS_FIRST  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINS_SECOND = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINS_THIRD  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BINS_FOURTH = 3'd4;

   // register reset values
   localparam logic [VARS_BITS-1:0] VARS_RESET = 3'd1;
   localparam logic [BINS_BITS-1:0] BINS_RESET = 4'd8;

   typedef enum logic [OP_BITS-1:0] {
      OP_ADD   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_UPDATE
   } state_type;

endpackage

`default_nettype wire

// ===== src/jhc_if.sv =====
`default_nettype none

// sample / query channel
interface jhc_req_if;
   import jhc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [OP_BITS-1:0]    operation;
   logic [VALUE_BITS-1:0] value_a;
   logic [VALUE_BITS-1:0] value_b;
   logic [VALUE_BITS-1:0] value_c;
   logic [VALUE_BITS-1:0] value_d;
   logic [MASK_BITS-1:0]  missing_mask;

   modport source (
      output valid, operation, value_a, value_b, value_c, value_d, missing_mask,
      input  ready
   );
   modport sink (
      input  valid, operation, value_a, value_b, value_c, value_d, missing_mask,
      output ready
   );
endinterface

// count result channel
interface jhc_rsp_if #(
   parameter int COUNT_BITS = jhc_pkg::COUNT_BITS_DEFAULT
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] count_out;
   logic                  bad_coordinate;

   modport source (
      output valid, count_out, bad_coordinate,
      input  ready
   );
   modport sink (
      input  valid, count_out, bad_coordinate,
      output ready
   );
endinterface

`default_nettype wire

// ===== src/joint_histogram_counter.sv =====
`default_nettype none

// channel     | dir | transaction
// ------------+-----+---------------------------------------------------------
// req_chan    | in  | add sample, read count at coordinates, or clear table
// rsp_chan    | out | count and bad-coordinate flag, one per read
// csr_*       | in  | register write, index 0 vars in use, 1..4 bin counts
//
// An add or read first issues the table read in S_IDLE, then in S_UPDATE
// writes back the incremented count or loads the result register.
// An ignored add (missing or out of range) and operation 3 stay in S_IDLE.
// A clear, and reset, sweeps the whole table of 2**(MAX_VARS*BIN_BITS) entries
// (4096 by default) at one entry a cycle, with req ready low.
// A read waits in S_UPDATE while the result register is still full.

module joint_histogram_counter #(
   parameter int MAX_VARS   = jhc_pkg::MAX_VARS_DEFAULT,
   parameter int BIN_BITS   = jhc_pkg::BIN_BITS_DEFAULT,
   parameter int COUNT_BITS = jhc_pkg::COUNT_BITS_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_write_enable,
   input  wire logic [jhc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [jhc_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   jhc_req_if.sink                                 req_chan,
   jhc_rsp_if.source                               rsp_chan
);
   import jhc_pkg::*;

   localparam int ADDR_BITS  = MAX_VARS * BIN_BITS;
   localparam int DEPTH      = 1 << ADDR_BITS;
   localparam int BIN_LIMIT  = 1 << BIN_BITS;
   localparam int USED_LIMIT = (MAX_VARS < VALUE_FIELDS) ? MAX_VARS : VALUE_FIELDS;

   // control registers
   logic [VARS_BITS-1:0] vars_in_use_ff;
   logic [BINS_BITS-1:0] bins_ff [VALUE_FIELDS];

   always_ff @(posedge clock) begin
      if (reset) begin
         vars_in_use_ff <= VARS_RESET;
         for (int i = 0; i < VALUE_FIELDS; i++) begin
            bins_ff[i] <= BINS_RESET;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_VARS_IN_USE: vars_in_use_ff <= csr_write_data[VARS_BITS-1:0];
            CSR_BINS_FIRST:  bins_ff[0] <= csr_write_data;
            CSR_BINS_SECOND: bins_ff[1] <= csr_write_data;
            CSR_BINS_THIRD:  bins_ff[2] <= csr_write_data;
            CSR_BINS_FOURTH: bins_ff[3] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // number of variables actually in use
   logic [VARS_BITS-1:0] vars_used;

   always_comb begin
      vars_used = vars_in_use_ff;
      if (vars_used == '0) begin
         vars_used = VARS_BITS'(1);
      end
      if (vars_used > VARS_BITS'(USED_LIMIT)) begin
         vars_used = VARS_BITS'(USED_LIMIT);
      end
   end

   // table address, range check and missing check of the incoming item
   logic [VALUE_BITS-1:0] req_value [VALUE_FIELDS];
   logic [ADDR_BITS-1:0]  req_addr;
   logic                  req_in_range;
   logic                  req_missing;

   assign req_value[0] = req_chan.value_a;
   assign req_value[1] = req_chan.value_b;
   assign req_value[2] = req_chan.value_c;
   assign req_value[3] = req_chan.value_d;

   always_comb begin
      req_addr     = '0;
      req_in_range = 1'b1;
      req_missing  = 1'b0;
      for (int i = 0; i < VALUE_FIELDS; i++) begin
         if (VARS_BITS'(i) < vars_used) begin
            if ({1'b0, req_value[i]} >= bins_ff[i]) begin
               req_in_range = 1'b0;
            end
            if (int'(req_value[i]) >= BIN_LIMIT) begin
               req_in_range = 1'b0;
            end
            req_addr = req_addr | (ADDR_BITS'(req_value[i]) << (BIN_BITS * i));
            if (req_chan.missing_mask[i]) begin
               req_missing = 1'b1;
            end
         end
      end
   end

   // state and item registers
   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clear_addr_ff, clear_addr_in;
   op_type               op_ff, op_in;
   logic [ADDR_BITS-1:0] addr_ff, addr_in;
   logic                 in_range_ff, in_range_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                 bad_ff, bad_in;

   op_type req_op;
   logic   req_accept;
   logic   rsp_free;

   assign req_op     = op_type'(req_chan.operation);
   assign req_accept = req_chan.valid && req_chan.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // table memory
   logic                  ram_wr_en;
   logic [ADDR_BITS-1:0]  ram_wr_addr;
   logic [COUNT_BITS-1:0] ram_wr_data;
   logic                  ram_rd_en;
   logic [COUNT_BITS-1:0] ram_rd_data;
   logic [COUNT_BITS-1:0] count_next;

   jhc_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (req_addr),
      .rd_data (ram_rd_data)
   );

   // saturating increment
   assign count_next = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_BITS'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (clear_addr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_op)
                  OP_ADD: begin
                     if (req_in_range && !req_missing) begin
                        state_in = S_UPDATE;
                     end
                  end
                  OP_READ:  state_in = S_UPDATE;
                  OP_CLEAR: state_in = S_CLEAR;
                  OP_NONE:  state_in = S_IDLE;
               endcase
            end
         end
         S_UPDATE: begin
            if (op_ff != OP_READ || rsp_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_chan.ready = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = addr_ff;
      ram_wr_data    = count_next;
      ram_rd_en      = 1'b0;
      clear_addr_in  = clear_addr_ff;
      op_in          = op_ff;
      addr_in        = addr_ff;
      in_range_in    = in_range_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      count_in       = count_ff;
      bad_in         = bad_ff;
      unique case (state_ff)
         S_CLEAR: begin
            ram_wr_en     = 1'b1;
            ram_wr_addr   = clear_addr_ff;
            ram_wr_data   = '0;
            clear_addr_in = clear_addr_ff + ADDR_BITS'(1);
         end
         S_IDLE: begin
            req_chan.ready = 1'b1;
            clear_addr_in  = '0;
            if (req_accept) begin
               ram_rd_en   = 1'b1;
               op_in       = req_op;
               addr_in     = req_addr;
               in_range_in = req_in_range;
            end
         end
         S_UPDATE: begin
            if (op_ff == OP_ADD) begin
               ram_wr_en = 1'b1;
            end else if (rsp_free) begin
               rsp_valid_in = 1'b1;
               count_in     = in_range_ff ? ram_rd_data : '0;
               bad_in       = !in_range_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clear_addr_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      in_range_ff <= in_range_in;
      count_ff    <= count_in;
      bad_ff      <= bad_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.count_out      = count_ff;
   assign rsp_chan.bad_coordinate = bad_ff;

endmodule

`default_nettype wire

// ===== src/jhc_ram.sv =====
`default_nettype none

module jhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port that holds when idle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== verif/tb_joint_histogram_counter.sv =====
`default_nettype none

module tb_joint_histogram_counter;
   import jhc_pkg::*;

   localparam int MAX_VARS    = MAX_VARS_DEFAULT;
   localparam int BIN_BITS    = BIN_BITS_DEFAULT;
   localparam int COUNT_BITS  = COUNT_BITS_DEFAULT;
   localparam int TABLE_DEPTH = 1 << (MAX_VARS * BIN_BITS);
   localparam int BIN_SPAN    = 1 << BIN_BITS;
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   // a clear sweeps 4096 entries with ready low, so allow well beyond that
   localparam int STALL_LIMIT   = 20000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_PHASES = 10;
   localparam int PHASE_OPS     = 60;
   localparam int BURST_ADDS    = 8;

   typedef logic [VALUE_FIELDS-1:0][VALUE_BITS-1:0] coord_set_type;

   typedef struct packed {
      op_type                kind;
      coord_set_type         coord;
      logic [MASK_BITS-1:0]  mask;
   } hist_op_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic                  bad;
   } bin_count_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data   = '0;

   jhc_req_if                          req_chan ();
   jhc_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_chan ();

   joint_histogram_counter #(
      .MAX_VARS  (MAX_VARS),
      .BIN_BITS  (BIN_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan)
   );

   // shadow of the histogram and its registers
   logic [COUNT_BITS-1:0] model_bins [TABLE_DEPTH];
   logic [VARS_BITS-1:0]  cfg_vars = VARS_RESET;
   logic [BINS_BITS-1:0]  cfg_bins [VALUE_FIELDS];

   hist_op_type   ops_to_send [$];
   bin_count_type counts_due [$];
   coord_set_type recent_coords [$];
   hist_op_type   drive_op;
   bin_count_type want;
   int         send_idle_pct = 0;
   int         recv_idle_pct = 0;
   int         mismatches = 0;
   int         stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int unsigned vars_used();
      if (cfg_vars == 0) return 1;
      if (cfg_vars > MAX_VARS) return MAX_VARS;
      return cfg_vars;
   endfunction

   function automatic logic [MASK_BITS-1:0] used_mask();
      return MASK_BITS'((1 << vars_used()) - 1);
   endfunction

   // table address of the used coordinates; returns 0 when one lies beyond its bins
   function automatic logic locate_bin(input coord_set_type c, output int unsigned addr);
      addr = 0;
      for (int i = 0; i < vars_used(); i++) begin
         if (c[i] >= cfg_bins[i]) return 1'b0;
         addr |= 32'(c[i]) << (BIN_BITS * i);
      end
      return 1'b1;
   endfunction

   // update the shadow table for one transaction and queue any count it returns
   task automatic tally_op(input hist_op_type op);
      int unsigned   addr;
      logic          hit;
      bin_count_type res;
      hit = locate_bin(op.coord, addr);
      case (op.kind)
         OP_ADD: begin
            if ((op.mask & used_mask()) == '0 && hit && model_bins[addr] != COUNT_MAX)
               model_bins[addr] = model_bins[addr] + 1'b1;
         end
         OP_READ: begin
            res.count = hit ? model_bins[addr] : '0;
            res.bad   = !hit;
            counts_due.push_back(res);
         end
         OP_CLEAR: begin
            foreach (model_bins[i]) model_bins[i] = '0;
         end
         default: ;
      endcase
   endtask

   // coordinates inside the current bin counts where any exist
   function automatic coord_set_type legal_coords(input coord_set_type seed);
      coord_set_type c;
      int unsigned   top;
      c = seed;
      for (int i = 0; i < VALUE_FIELDS; i++) begin
         top = (cfg_bins[i] > BIN_SPAN) ? BIN_SPAN : cfg_bins[i];
         if (top != 0) c[i] = VALUE_BITS'($urandom_range(top - 1));
      end
      return c;
   endfunction

   task automatic queue_op(input op_type kind, input int a, input int b, input int c,
                           input int d, input int mask);
      hist_op_type op;
      op.kind  = kind;
      op.coord = {VALUE_BITS'(d), VALUE_BITS'(c), VALUE_BITS'(b), VALUE_BITS'(a)};
      op.mask  = MASK_BITS'(mask);
      ops_to_send.push_back(op);
   endtask

   // mostly well-formed adds and reads near filled bins, some noise
   task automatic queue_random_phase(input int n_ops);
      hist_op_type op;
      int          r;
      for (int k = 0; k < n_ops; k++) begin
         r = $urandom_range(99);
         op.mask = MASK_BITS'($urandom_range(15));
         for (int i = 0; i < VALUE_FIELDS; i++)
            op.coord[i] = VALUE_BITS'($urandom_range(BIN_SPAN - 1));
         if (r < 2) begin
            op.kind = OP_CLEAR;
         end else if (r < 5) begin
            op.kind = OP_NONE;
         end else if (r < 62) begin
            op.kind = OP_ADD;
            if ($urandom_range(99) < 85) begin
               if (recent_coords.size() != 0 && $urandom_range(99) < 40)
                  op.coord = recent_coords[$urandom_range(recent_coords.size() - 1)];
               else
                  op.coord = legal_coords(op.coord);
               op.mask = op.mask & ~used_mask();
            end
            recent_coords.push_back(op.coord);
            if (recent_coords.size() > 16) void'(recent_coords.pop_front());
         end else begin
            op.kind = OP_READ;
            r = $urandom_range(99);
            if (r < 60 && recent_coords.size() != 0)
               op.coord = recent_coords[$urandom_range(recent_coords.size() - 1)];
            else if (r < 85)
               op.coord = legal_coords(op.coord);
         end
         ops_to_send.push_back(op);
      end
      // closing read: its count arrives only after everything before it is done
      op.kind  = OP_READ;
      op.coord = legal_coords(op.coord);
      ops_to_send.push_back(op);
   endtask

   // sender holds off until every queued transaction and count is through
   task automatic wait_quiet();
      do @(negedge clock);
      while (ops_to_send.size() != 0 || req_chan.valid || counts_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] idx, input int unsigned data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= CSR_DATA_BITS'(data);
   endtask

   task automatic write_settings(input int unsigned vars, input int unsigned b0,
                                 input int unsigned b1, input int unsigned b2,
                                 input int unsigned b3);
      wait_quiet();
      write_reg(CSR_VARS_IN_USE, vars);
      write_reg(CSR_BINS_FIRST, b0);
      write_reg(CSR_BINS_SECOND, b1);
      write_reg(CSR_BINS_THIRD, b2);
      write_reg(CSR_BINS_FOURTH, b3);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      cfg_vars    = VARS_BITS'(vars);
      cfg_bins[0] = BINS_BITS'(b0);
      cfg_bins[1] = BINS_BITS'(b1);
      cfg_bins[2] = BINS_BITS'(b2);
      cfg_bins[3] = BINS_BITS'(b3);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (ops_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            drive_op = ops_to_send.pop_front();
            req_chan.valid        <= 1'b1;
            req_chan.operation    <= drive_op.kind;
            req_chan.value_a      <= drive_op.coord[0];
            req_chan.value_b      <= drive_op.coord[1];
            req_chan.value_c      <= drive_op.coord[2];
            req_chan.value_d      <= drive_op.coord[3];
            req_chan.missing_mask <= drive_op.mask;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // result backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: check counts, then predict from accepted requests
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (counts_due.size() == 0) begin
               $error("unexpected count transaction: count_out %0d bad_coordinate %0d",
                      rsp_chan.count_out, rsp_chan.bad_coordinate);
               mismatches++;
            end else begin
               want = counts_due.pop_front();
               if (rsp_chan.count_out !== want.count) begin
                  $error("count_out: expected %0d, actual %0d", want.count, rsp_chan.count_out);
                  mismatches++;
               end
               if (rsp_chan.bad_coordinate !== want.bad) begin
                  $error("bad_coordinate: expected %0d, actual %0d",
                         want.bad, rsp_chan.bad_coordinate);
                  mismatches++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            tally_op({op_type'(req_chan.operation),
                      req_chan.value_d, req_chan.value_c, req_chan.value_b, req_chan.value_a,
                      req_chan.missing_mask});
         end
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("FAIL joint_histogram_counter");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      int unsigned vr;
      int unsigned bn [VALUE_FIELDS];
      req_chan.valid        = 1'b0;
      req_chan.operation    = OP_NONE;
      req_chan.value_a      = '0;
      req_chan.value_b      = '0;
      req_chan.value_c      = '0;
      req_chan.value_d      = '0;
      req_chan.missing_mask = '0;
      rsp_chan.ready        = 1'b0;
      foreach (model_bins[i]) model_bins[i] = '0;
      foreach (cfg_bins[i]) cfg_bins[i] = BINS_RESET;
      send_idle_pct = 10;
      recv_idle_pct = 51;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // reset settings: one variable, eight bins each
      queue_op(OP_READ,  0, 0, 0, 0, 0);
      queue_op(OP_ADD,   7, 0, 0, 0, 0);
      queue_op(OP_ADD,   7, 5, 3, 1, 4'b1110);   // unused values and missing bits ignored
      queue_op(OP_ADD,   0, 7, 7, 7, 0);
      queue_op(OP_ADD,   3, 0, 0, 0, 4'b0001);   // missing, not counted
      queue_op(OP_NONE,  3, 0, 0, 0, 0);
      queue_op(OP_READ,  7, 7, 7, 7, 4'b1111);   // mask has no effect on a read
      queue_op(OP_READ,  3, 0, 0, 0, 0);
      queue_op(OP_CLEAR, 0, 0, 0, 0, 0);
      queue_op(OP_READ,  7, 0, 0, 0, 0);

      // four variables, single-bin second, fourth above the bin span
      write_settings(4, 8, 1, 8, 15);
      queue_op(OP_ADD,  7, 0, 7, 7, 0);
      queue_op(OP_ADD,  7, 0, 7, 7, 0);
      queue_op(OP_ADD,  7, 1, 7, 7, 0);
      queue_op(OP_ADD,  7, 0, 7, 7, 4'b1000);
      queue_op(OP_READ, 7, 0, 7, 7, 0);
      queue_op(OP_READ, 7, 1, 7, 7, 0);
      queue_op(OP_READ, 0, 0, 0, 7, 0);

      // used variable with no bins
      write_settings(3, 8, 8, 0, 8);
      queue_op(OP_ADD,  1, 1, 0, 0, 0);
      queue_op(OP_READ, 1, 1, 0, 0, 0);

      // vars in use zero acts as one; counts survive register changes
      write_settings(0, 8, 8, 8, 8);
      queue_op(OP_ADD,  6, 3, 3, 3, 4'b0010);
      queue_op(OP_READ, 6, 3, 3, 3, 0);

      // vars in use above the maximum saturates
      write_settings(7, 8, 8, 8, 8);
      queue_op(OP_READ, 7, 0, 7, 7, 0);
      queue_op(OP_READ, 6, 0, 0, 0, 0);

      // random phases, each under its own settings
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (p == 0) begin
            vr = 4;
            foreach (bn[i]) bn[i] = BIN_SPAN;
         end else begin
            vr = ($urandom_range(99) < 85) ? $urandom_range(MAX_VARS, 1) : $urandom_range(7);
            foreach (bn[i])
               bn[i] = ($urandom_range(99) < 80) ? $urandom_range(BIN_SPAN, 1)
                                                 : $urandom_range(15);
         end
         write_settings(vr, bn[0], bn[1], bn[2], bn[3]);
         if (p == 4) begin
            send_idle_pct = 51;
            recv_idle_pct = 10;
         end else if (p == 8) begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         queue_random_phase(PHASE_OPS);
      end

      // back-to-back adds to one bin at full rate
      write_settings(1, 8, 8, 8, 8);
      queue_op(OP_CLEAR, 0, 0, 0, 0, 0);
      for (int k = 0; k < BURST_ADDS; k++) begin
         queue_op(OP_ADD, 5, 0, 0, 0, 0);
      end
      queue_op(OP_READ, 5, 0, 0, 0, 0);
      queue_op(OP_READ, 4, 0, 0, 0, 0);

      wait_quiet();
      if (mismatches == 0) begin
         $display("PASS joint_histogram_counter");
      end else begin
         $display("FAIL joint_histogram_counter");
      end
      $finish;
   end

endmodule

`default_nettype wire
